FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL files of the SHA-256 hasher.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SHA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: sv/sha_pkg.sv
// Package for the SHA-256 stream hasher: word type, round constants,
// initial hash values and the round/schedule mixing functions. No dependencies.
`default_nettype none

package sha_pkg;

  typedef logic [31:0] word_t;

  // Input beat opcode
  localparam logic OP_FINISH = 1'b1;

  // Padding and counting constants
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] RND_LAST  = 6'd63;
  localparam logic [2:0] IDX_LAST  = 3'd7;

  localparam word_t SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Round functions (fixed rotations and shifts written as concatenations)
  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t ch_fn(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t maj_fn(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

FILE: sv/sha_if.sv
// Handshake interfaces of the SHA-256 hasher: byte input channel and
// digest word output channel. No dependencies.
`default_nettype none

interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

FILE: sv/sha256_stream_hasher_core.sv
// SHA-256 stream hasher top level: byte intake, padding sequencer and a
// single round unit reused for all 64 rounds. Uses sha_pkg, sha_if, assert_macros.svh.
//
//   channel  dir  beat payload                          handshake
//   in_ch    in   op, data_byte                         valid/ready
//   out_ch   out  digest_word, word_index, last_word    valid/ready
//
// Absorb beat: the 64th byte of a block starts 64 rounds, then a fold into
//   the hash (one round per cycle in the shared round adder tree).
// Finish beat: pad bytes one per cycle, rounds and fold, twice when fill >= 56,
//   then 8 digest beats, one per cycle while out_ch.ready is high.
// Reset (rst_n low, synchronous) loads the initial hash and clears all counters.
// in_ch.ready is high only when idle; a stalled digest beat holds its word.
`default_nettype none
`include "assert_macros.svh"

module sha256_stream_hasher_core
  import sha_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  sha_in_if.sink      in_ch,
  sha_out_if.source   out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Control state
  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [54:0] blk_r, blk_nxt;      // compressed blocks, bit length = blk * 512
  logic [5:0]  rnd_r, rnd_nxt;
  logic        fin_r, fin_nxt;      // finish in progress
  logic        mark_r, mark_nxt;    // 0x80 byte already placed
  logic        lenok_r, lenok_nxt;  // current pad block carries the length
  logic [2:0]  idx_r, idx_nxt;
  word_t       hash_r [8];
  word_t       hash_nxt [8];

  // Datapath state
  word_t       sched_r [16];        // message window, entry 0 is the oldest word
  word_t       sched_nxt [16];
  word_t       v_r [8];
  word_t       v_nxt [8];
  logic [63:0] len_r, len_nxt;

  logic        in_fire, out_fire;
  logic        shift_en;
  logic [7:0]  shift_byte;
  word_t       w_new, t1, t2;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // Shared round unit and schedule expansion
  assign w_new = ssig1(sched_r[14]) + sched_r[9] + ssig0(sched_r[1]) + sched_r[0];
  assign t1    = v_r[7] + bsig1(v_r[4]) + ch_fn(v_r[4], v_r[5], v_r[6]) +
                 SHA_K[rnd_r] + sched_r[0];
  assign t2    = bsig0(v_r[0]) + maj_fn(v_r[0], v_r[1], v_r[2]);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    blk_nxt    = blk_r;
    rnd_nxt    = rnd_r;
    fin_nxt    = fin_r;
    mark_nxt   = mark_r;
    lenok_nxt  = lenok_r;
    idx_nxt    = idx_r;
    hash_nxt   = hash_r;
    sched_nxt  = sched_r;
    v_nxt      = v_r;
    len_nxt    = len_r;
    shift_en   = 1'b0;
    shift_byte = in_ch.data_byte;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.op == OP_FINISH) begin
            fin_nxt   = 1'b1;
            mark_nxt  = 1'b0;
            lenok_nxt = 1'b0;
            len_nxt   = {blk_r, fill_r, 3'b000};
            state_nxt = S_PAD;
          end else begin
            shift_en = 1'b1;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == FILL_LAST) begin
              blk_nxt   = blk_r + 55'd1;
              v_nxt     = hash_r;
              state_nxt = S_COMP;
            end
          end
        end
      end

      // one pad byte per cycle: marker, zeros, then big-endian length
      S_PAD: begin
        shift_en = 1'b1;
        fill_nxt = fill_r + 6'd1;
        if (!mark_r) begin
          shift_byte = PAD_MARK;
          mark_nxt   = 1'b1;
          lenok_nxt  = (fill_r < LEN_POS);
        end else if (lenok_r && (fill_r >= LEN_POS)) begin
          shift_byte = len_r[63:56];
          len_nxt    = {len_r[55:0], 8'h00};
        end else begin
          shift_byte = 8'h00;
        end
        if (fill_r == FILL_LAST) begin
          v_nxt     = hash_r;
          state_nxt = S_COMP;
        end
      end

      // one round per cycle; window slides by one word
      S_COMP: begin
        for (int i = 0; i < 15; i++) begin
          sched_nxt[i] = sched_r[i+1];
        end
        sched_nxt[15] = w_new;
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == RND_LAST) begin
          state_nxt = S_FOLD;
        end
      end

      S_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + v_r[i];
        end
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (lenok_r) begin
          idx_nxt   = 3'd0;
          state_nxt = S_OUT;
        end else begin
          lenok_nxt = 1'b1;
          state_nxt = S_PAD;
        end
      end

      S_OUT: begin
        if (out_fire) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == IDX_LAST) begin
            hash_nxt  = SHA_IV;
            fill_nxt  = 6'd0;
            blk_nxt   = 55'd0;
            fin_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // byte intake: whole window shifts left by one byte
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        sched_nxt[i] = {sched_r[i][23:0], sched_r[i+1][31:24]};
      end
      sched_nxt[15] = {sched_r[15][23:0], shift_byte};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= 6'd0;
      blk_r   <= 55'd0;
      rnd_r   <= 6'd0;
      fin_r   <= 1'b0;
      mark_r  <= 1'b0;
      lenok_r <= 1'b0;
      idx_r   <= 3'd0;
      hash_r  <= SHA_IV;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      blk_r   <= blk_nxt;
      rnd_r   <= rnd_nxt;
      fin_r   <= fin_nxt;
      mark_r  <= mark_nxt;
      lenok_r <= lenok_nxt;
      idx_r   <= idx_nxt;
      hash_r  <= hash_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    sched_r <= sched_nxt;
    v_r     <= v_nxt;
    len_r   <= len_nxt;
  end

  // Ports
  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.digest_word = hash_r[idx_r];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == IDX_LAST);

  // Checks
  `SHA_ASSERT_SAME(a_rnd_idle, clk, rst_n, state_r != S_COMP, rnd_r == 6'd0)
  `SHA_ASSERT_SAME(a_out_aligned, clk, rst_n, state_r == S_OUT, fill_r == 6'd0 && mark_r)
  `SHA_ASSERT_NEXT(a_fin_start, clk, rst_n, in_fire && in_ch.op == OP_FINISH,
                   state_r == S_PAD && !mark_r && fin_r)
  `SHA_ASSERT_NEXT(a_digest_done, clk, rst_n, out_fire && out_ch.last_word,
                   state_r == S_IDLE && hash_r[0] == SHA_IV[0] && blk_r == 55'd0)

endmodule

`default_nettype wire
